// ===== hw/rtl/local_binary_pattern_stream_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the local binary pattern stream
// Each macro builds one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOCAL_BINARY_PATTERN_STREAM_MACROS_SVH
`define LOCAL_BINARY_PATTERN_STREAM_MACROS_SVH

// Same-cycle implication
`define LBP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, word types and neighbour offsets for the LBP stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int RADIUS_DEF    = 1;

    localparam int NEIGHBOURS    = 8;
    localparam int HEIGHT_LIMIT  = 2048;

    // Field and register widths
    localparam int PIX_W         = 8;
    localparam int SIZE_W        = 12;
    localparam int THR_W         = 8;
    localparam int ROW_W         = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;

    // Register reset values
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int THR_RESET     = 0;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_THRESHOLD = 2'd2
    } cfg_reg_t;

    // Input word kinds
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef struct packed {
        op_t              operation;
        logic [PIX_W-1:0] pixel;
    } pix_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pattern_code;
        logic             last_of_frame;
    } code_word_t;

    // Per-word position info from the raster tracker
    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [NEIGHBOURS-1:0] inside_mask;
    } pos_info_t;

    // Rounded diagonal offset, round(r / sqrt2)
    function automatic int diag_offset(input int radius);
        return (radius * 181 + 128) >>> 8;
    endfunction

    // Horizontal offset of neighbour k, counter-clockwise from the right
    function automatic int offset_x(input int k, input int radius);
        int d;
        int dx;
        d = diag_offset(radius);
        unique case (k)
            0:       dx = radius;
            1:       dx = d;
            2:       dx = 0;
            3:       dx = -d;
            4:       dx = -radius;
            5:       dx = -d;
            6:       dx = 0;
            default: dx = d;
        endcase
        return dx;
    endfunction

    // Vertical offset of neighbour k, y grows downward
    function automatic int offset_y(input int k, input int radius);
        int d;
        int dy;
        d = diag_offset(radius);
        unique case (k)
            0:       dy = 0;
            1:       dy = -d;
            2:       dy = -radius;
            3:       dy = -d;
            4:       dy = 0;
            5:       dy = d;
            6:       dy = radius;
            default: dy = d;
        endcase
        return dy;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_line_store.sv =====
// ----------------------------------------------------------------------------
// lbp_line_store
// Column-addressed store of the last rows; one read and one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_line_store #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; same-address write is forwarded (one-column frames)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= store_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_position.sv =====
// ----------------------------------------------------------------------------
// lbp_position
// Raster tracker: input column, fill count, centre position, edge masks.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_position #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = lbp_pkg::RADIUS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire logic                          advance,
    input  wire logic [lbp_pkg::SIZE_W-1:0]    eff_width,
    input  wire logic [lbp_pkg::SIZE_W-1:0]    eff_height,
    output logic      [$clog2(MAX_WIDTH)-1:0]  col,
    output lbp_pkg::pos_info_t                 info
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SIZE_W = lbp_pkg::SIZE_W;
    localparam int ROW_W  = lbp_pkg::ROW_W;
    localparam int LAG_W  = SIZE_W + $clog2(RADIUS + 1) + 1;
    localparam int EXT_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 2;
    localparam int YEXT_W = ROW_W + 2;

    logic [COL_W-1:0] col_reg,     col_next;
    logic [LAG_W-1:0] fill_reg,    fill_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [LAG_W-1:0] lag;
    logic             emit;
    logic             col_wrap;
    logic             out_col_wrap;
    logic             out_row_end;
    logic             last;
    logic [lbp_pkg::NEIGHBOURS-1:0] inside_mask;

    // Codes start once RADIUS rows plus RADIUS words have gone by
    assign lag  = LAG_W'(RADIUS) * LAG_W'(eff_width) + LAG_W'(RADIUS);
    assign emit = (fill_reg == lag);

    assign col_wrap     = (EXT_W'(col_reg) + EXT_W'(1)) == EXT_W'(eff_width);
    assign out_col_wrap = (EXT_W'(out_col_reg) + EXT_W'(1)) == EXT_W'(eff_width);
    assign out_row_end  = (YEXT_W'(out_row_reg) + YEXT_W'(1)) == YEXT_W'(eff_height);
    assign last         = emit && out_col_wrap && out_row_end;

    // Neighbour inside-image checks for the current centre
    for (genvar k = 0; k < lbp_pkg::NEIGHBOURS; k++)
    begin : g_mask
        localparam int DX = lbp_pkg::offset_x(k, RADIUS);
        localparam int DY = lbp_pkg::offset_y(k, RADIUS);
        logic x_ok;
        logic y_ok;

        if (DX >= 0)
        begin : g_xp
            assign x_ok = (EXT_W'(out_col_reg) + EXT_W'(DX)) < EXT_W'(eff_width);
        end
        else
        begin : g_xn
            assign x_ok = EXT_W'(out_col_reg) >= EXT_W'(-DX);
        end

        if (DY >= 0)
        begin : g_yp
            assign y_ok = (YEXT_W'(out_row_reg) + YEXT_W'(DY)) < YEXT_W'(eff_height);
        end
        else
        begin : g_yn
            assign y_ok = YEXT_W'(out_row_reg) >= YEXT_W'(-DY);
        end

        assign inside_mask[k] = x_ok & y_ok;
    end

    // Counter update
    always_comb
    begin
        col_next     = col_reg;
        fill_next    = fill_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            col_next     = '0;
            fill_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (advance)
        begin
            col_next = col_wrap ? '0 : col_reg + 1'b1;
            if (!emit)
            begin
                fill_next = fill_reg + 1'b1;
            end
            else if (out_col_wrap)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
            // Frame done: next word starts a new frame
            if (last)
            begin
                col_next     = '0;
                fill_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            fill_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            fill_reg    <= fill_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign col              = col_reg;
    assign info.emit        = emit;
    assign info.last        = last;
    assign info.inside_mask = inside_mask;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_window.sv =====
// ----------------------------------------------------------------------------
// lbp_window
// Square pixel window and the eight neighbour compares of the pattern code.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_window #(
    parameter int RADIUS = lbp_pkg::RADIUS_DEF
) (
    input  wire logic                                                 clk,
    input  wire logic                                                 rst_n,
    input  wire logic                                                 shift,
    input  wire logic [2*RADIUS:0][lbp_pkg::PIX_W-1:0]                column,
    input  wire logic [lbp_pkg::THR_W-1:0]                            threshold,
    input  wire logic [lbp_pkg::NEIGHBOURS-1:0]                       inside_mask,
    output logic      [lbp_pkg::NEIGHBOURS-1:0]                       code
);

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int PIX_W = lbp_pkg::PIX_W;

    // win_reg[column][row]: column SPAN-1 newest, row 0 bottom
    logic [SPAN-1:0][SPAN-1:0][PIX_W-1:0] win_reg;
    logic [PIX_W:0]                       limit;

    // Shift in one column per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            for (int j = 0; j < SPAN - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[SPAN-1] <= column;
        end
    end

    assign limit = {1'b0, win_reg[RADIUS][RADIUS]} + {1'b0, threshold};

    // Outside pixels read as zero, so they pass only when the limit is zero
    for (genvar k = 0; k < lbp_pkg::NEIGHBOURS; k++)
    begin : g_bit
        localparam int DX      = lbp_pkg::offset_x(k, RADIUS);
        localparam int DY      = lbp_pkg::offset_y(k, RADIUS);
        localparam int COL_IDX = RADIUS + DX;
        localparam int ROW_IDX = RADIUS - DY;

        assign code[k] = inside_mask[k] ? ({1'b0, win_reg[COL_IDX][ROW_IDX]} >= limit)
                                        : (limit == '0);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/local_binary_pattern_stream.sv =====
// ----------------------------------------------------------------------------
// local_binary_pattern_stream
// Eight-neighbour local binary pattern of a raster-order gray pixel stream.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                Word
// cfg      in   cfg_write                cfg_index, cfg_data
// pix      in   pix_valid / pix_stall    lbp_pkg::pix_word_t
// code     out  code_valid / code_stall  lbp_pkg::code_word_t
//
// One word per clock sustained while code_stall is low; each code word
// passes stage 1, the window and the output register after the word that
// completes its window. One line-store read and write per word set that rate.
// A code trails its pixel by RADIUS rows plus RADIUS words; flush words pad.
// Reset clears control, sets 640x480 and threshold 0; the line store is not
// cleared, stale rows are masked as outside the image.
// code_stall holds the output word; pix_stall rises only when all stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module local_binary_pattern_stream #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = lbp_pkg::RADIUS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire lbp_pkg::pix_word_t                pix_word,
    output logic                                   code_valid,
    input  wire logic                              code_stall,
    output lbp_pkg::code_word_t                    code_word
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W    = lbp_pkg::PIX_W;
    localparam int SIZE_W   = lbp_pkg::SIZE_W;
    localparam int THR_W    = lbp_pkg::THR_W;
    localparam int LINE_W   = 2 * RADIUS * PIX_W;
    localparam int MW_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W    = (MW_BITS > SIZE_W) ? MW_BITS : SIZE_W;

    // Configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              restart;
    logic [SIZE_W-1:0] eff_width;
    logic [SIZE_W-1:0] eff_height;

    // Pipeline
    logic                   pix_accept;
    logic [COL_W-1:0]       pos_col;
    lbp_pkg::pos_info_t     pos_info;

    logic                   s1_valid_reg;
    logic [PIX_W-1:0]       s1_pixel_reg;
    logic [COL_W-1:0]       s1_col_reg;
    lbp_pkg::pos_info_t     s1_info_reg;
    logic                   s1_move;

    logic                   s2_valid_reg;
    lbp_pkg::pos_info_t     s2_info_reg;
    logic                   code_move;

    logic                   out_valid_reg;
    lbp_pkg::code_word_t    out_word_reg;

    logic [LINE_W-1:0]      line_rd;
    logic [PIX_W-1:0]       code;

    // Register writes; a size write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(lbp_pkg::WIDTH_RESET);
            height_reg <= SIZE_W'(lbp_pkg::HEIGHT_RESET);
            thr_reg    <= THR_W'(lbp_pkg::THR_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lbp_pkg::REG_WIDTH:     width_reg  <= cfg_data[SIZE_W-1:0];
                lbp_pkg::REG_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                lbp_pkg::REG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:                ;
            endcase
        end
    end

    assign restart = cfg_write && ((cfg_index == lbp_pkg::REG_WIDTH) ||
                                   (cfg_index == lbp_pkg::REG_HEIGHT));

    // Clamp frame size to the supported range
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = SIZE_W'(1);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            eff_width = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end

        if (height_reg == '0)
        begin
            eff_height = SIZE_W'(1);
        end
        else if (height_reg > SIZE_W'(lbp_pkg::HEIGHT_LIMIT))
        begin
            eff_height = SIZE_W'(lbp_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    // Stage handshakes
    assign code_move  = s2_valid_reg && (!out_valid_reg || !code_stall);
    assign s1_move    = s1_valid_reg && (!s2_valid_reg || code_move);
    assign pix_stall  = s1_valid_reg && !s1_move;
    assign pix_accept = pix_valid && !pix_stall;

    lbp_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .advance    (pix_accept),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .col        (pos_col),
        .info       (pos_info)
    );

    // Line store: read the column above on accept, write it back shifted
    lbp_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (pix_accept),
        .rd_addr (pos_col),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data ({line_rd[LINE_W-PIX_W-1:0], s1_pixel_reg}),
        .rd_data (line_rd)
    );

    // Stage 1: accepted word and its position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= (pix_word.operation == lbp_pkg::OP_FLUSH) ? '0 : pix_word.pixel;
            s1_col_reg   <= pos_col;
            s1_info_reg  <= pos_info;
        end
    end

    // Stage 2: window holds the centre; only code-bearing words occupy it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= s1_info_reg.emit;
        end
        else if (code_move)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_info_reg <= s1_info_reg;
        end
    end

    lbp_window #(
        .RADIUS (RADIUS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift       (s1_move),
        .column      ({line_rd, s1_pixel_reg}),
        .threshold   (thr_reg),
        .inside_mask (s2_info_reg.inside_mask),
        .code        (code)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (code_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!code_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_move)
        begin
            out_word_reg.pattern_code  <= code;
            out_word_reg.last_of_frame <= s2_info_reg.last;
        end
    end

    assign code_valid = out_valid_reg;
    assign code_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_checker.sv =====
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the LBP stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "local_binary_pattern_stream_macros.svh"

module lbp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                pix_valid,
    input wire logic                pix_stall,
    input wire logic                code_valid,
    input wire logic                code_stall,
    input wire lbp_pkg::code_word_t code_word
);

    // Stalled output word stays offered
    `LBP_ASSERT_NEXT(a_code_valid_held, code_valid && code_stall, code_valid, "code word dropped while stalled")

    // Stalled output word keeps its value
    `LBP_ASSERT_NEXT(a_code_word_held, code_valid && code_stall, $stable(code_word), "code word changed while stalled")

    // Input backs up only behind a full, stalled output
    `LBP_ASSERT_IMPL(a_stall_from_output, pix_stall, code_valid && code_stall, "input stalled with output free")

    // Three register stages lie between input and output
    `LBP_ASSERT_IMPL(a_min_latency, $past(!rst_n, 3), !code_valid, "code word too soon after reset")

    // Input side is only observed through the stall check above
    logic unused_pix_valid;
    assign unused_pix_valid = pix_valid;

endmodule

bind local_binary_pattern_stream lbp_checker u_lbp_checker (.*);

`default_nettype wire
